### src/fcr_pkg.sv
// Shared constants and widths for the filled circle rasterizer.
package fcr_pkg;

    // Largest diameter honoured; larger requests saturate to it
    localparam int MAX_DIAMETER  = 1024;
    // Largest effective frame dimension; larger register values saturate to it
    localparam int MAX_FRAME_DIM = 4096;

    // Field widths fixed by the interface
    localparam int COORD_W = 13;
    localparam int DIAM_W  = 11;
    localparam int DIM_W   = 13;
    localparam int ADDR_W  = 26;
    localparam int CHAN_W  = 8;

    // Derived internal widths
    localparam int HALF_W = $clog2(MAX_DIAMETER / 2 + 1);   // half size
    localparam int SPAN_W = HALF_W + 1;                      // 2 * half size
    localparam int OFS_W  = SPAN_W;                          // signed offset from centre
    localparam int POS_W  = COORD_W + 1;                     // signed absolute position
    localparam int SQ_W   = 2 * HALF_W;                      // one squared offset
    localparam int SUM_W  = SQ_W + 1;                        // sum of two squares

    localparam logic [DIAM_W-1:0] DIAM_LIMIT = DIAM_W'(MAX_DIAMETER);
    localparam logic [DIM_W-1:0]  DIM_LIMIT  = DIM_W'(MAX_FRAME_DIM);

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Input actions
    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

endpackage

### src/filled_circle_rasterizer.sv
// Filled circle rasterizer: bounding-box scan with circle and frame clipping.
//
//   channel  | handshake               | word
//   ---------+-------------------------+----------------------------------------
//   s_       | s_valid / s_ready       | action, centre, diameter, RGBA colour
//   m_       | m_valid / m_ready       | write enable, byte address, RGBA, last
//   cfg_     | cfg_write (no wait)     | frame_width / frame_height
//
// One word in, one word out; a new word can be taken every cycle. The scan
// position and the output register are both updated at the accepting edge,
// so a result is offered the cycle after its word is taken. The output
// register drains while a new word is taken, so the rate is one per clock
// unless m_ready is held low. Reset is synchronous, active low, and leaves
// the block idle with a 640x480 frame.
module filled_circle_rasterizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [fcr_pkg::DIM_W-1:0]     cfg_data,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [fcr_pkg::COORD_W-1:0]   s_center_x,
    input  logic [fcr_pkg::COORD_W-1:0]   s_center_y,
    input  logic [fcr_pkg::DIAM_W-1:0]    s_diameter,
    input  logic [fcr_pkg::CHAN_W-1:0]    s_red,
    input  logic [fcr_pkg::CHAN_W-1:0]    s_green,
    input  logic [fcr_pkg::CHAN_W-1:0]    s_blue,
    input  logic [fcr_pkg::CHAN_W-1:0]    s_alpha,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_write_enable,
    output logic [fcr_pkg::ADDR_W-1:0]    m_byte_address,
    output logic [fcr_pkg::CHAN_W-1:0]    m_out_red,
    output logic [fcr_pkg::CHAN_W-1:0]    m_out_green,
    output logic [fcr_pkg::CHAN_W-1:0]    m_out_blue,
    output logic [fcr_pkg::CHAN_W-1:0]    m_out_alpha,
    output logic                          m_last_position
);
    import fcr_pkg::*;

    // Configuration registers
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;

    // Scan state
    logic [HALF_W-1:0]  scan_col_reg, scan_col_next;
    logic [HALF_W-1:0]  scan_row_reg, scan_row_next;
    logic [COORD_W-1:0] center_x_reg, center_x_next;
    logic [COORD_W-1:0] center_y_reg, center_y_next;
    logic [HALF_W-1:0]  half_size_reg, half_size_next;
    logic [CHAN_W-1:0]  red_reg, red_next, green_reg, green_next;
    logic [CHAN_W-1:0]  blue_reg, blue_next, alpha_reg, alpha_next;
    logic               active_reg, active_next;

    // Output register
    logic               m_valid_reg;
    logic               we_reg, we_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic               last_reg, last_next;

    logic accept;

    // Datapath for the current scan position
    logic [DIAM_W-1:0]      diam_sat;
    logic [SPAN_W-1:0]      span;
    logic [OFS_W-1:0]       dx, dy, abs_dx, abs_dy;
    logic [HALF_W-1:0]      mag_dx, mag_dy;
    logic [SQ_W-1:0]        sq_dx, sq_dy, sq_h;
    logic [SUM_W-1:0]       sq_sum;
    logic [POS_W-1:0]       pos_x, pos_y;
    logic [DIM_W-1:0]       eff_w, eff_h;
    logic                   in_circle, in_frame;
    logic [ADDR_W-1:0]      row_base, pixel_index;
    logic [SPAN_W-1:0]      row_inc, col_inc;

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    // Offsets from the centre and circle test
    always_comb begin
        span      = {half_size_reg, 1'b0};
        dx        = {1'b0, scan_col_reg} - {1'b0, half_size_reg};
        dy        = {1'b0, scan_row_reg} - {1'b0, half_size_reg};
        abs_dx    = dx[OFS_W-1] ? (~dx + OFS_W'(1)) : dx;
        abs_dy    = dy[OFS_W-1] ? (~dy + OFS_W'(1)) : dy;
        mag_dx    = abs_dx[HALF_W-1:0];
        mag_dy    = abs_dy[HALF_W-1:0];
        sq_dx     = mag_dx * mag_dx;
        sq_dy     = mag_dy * mag_dy;
        sq_h      = half_size_reg * half_size_reg;
        sq_sum    = {1'b0, sq_dx} + {1'b0, sq_dy};
        in_circle = sq_sum < {1'b0, sq_h};
    end

    // Absolute position, frame clip and byte address
    always_comb begin
        pos_x    = {center_x_reg[COORD_W-1], center_x_reg}
                 + {{(POS_W-OFS_W){dx[OFS_W-1]}}, dx};
        pos_y    = {center_y_reg[COORD_W-1], center_y_reg}
                 + {{(POS_W-OFS_W){dy[OFS_W-1]}}, dy};
        eff_w    = (frame_width_reg  > DIM_LIMIT) ? DIM_LIMIT : frame_width_reg;
        eff_h    = (frame_height_reg > DIM_LIMIT) ? DIM_LIMIT : frame_height_reg;
        in_frame = !pos_x[POS_W-1] && (pos_x[DIM_W-1:0] < eff_w)
                && !pos_y[POS_W-1] && (pos_y[DIM_W-1:0] < eff_h);
        row_base    = ADDR_W'(eff_w * pos_y[DIM_W-1:0]);
        pixel_index = row_base + ADDR_W'(pos_x[DIM_W-1:0]);
    end

    // Next state and next result word
    always_comb begin
        diam_sat       = (s_diameter > DIAM_LIMIT) ? DIAM_LIMIT : s_diameter;
        row_inc        = {1'b0, scan_row_reg} + SPAN_W'(1);
        col_inc        = {1'b0, scan_col_reg} + SPAN_W'(1);

        scan_col_next  = scan_col_reg;
        scan_row_next  = scan_row_reg;
        center_x_next  = center_x_reg;
        center_y_next  = center_y_reg;
        half_size_next = half_size_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        alpha_next     = alpha_reg;
        active_next    = active_reg;
        we_next        = 1'b0;
        addr_next      = '0;
        last_next      = 1'b1;

        if (s_action == ACT_START) begin
            center_x_next  = s_center_x;
            center_y_next  = s_center_y;
            half_size_next = diam_sat[DIAM_W-1:1];
            red_next       = s_red;
            green_next     = s_green;
            blue_next      = s_blue;
            alpha_next     = s_alpha;
            scan_col_next  = '0;
            scan_row_next  = '0;
            active_next    = (diam_sat[DIAM_W-1:1] != '0);
            last_next      = (diam_sat[DIAM_W-1:1] == '0);
        end else if (active_reg) begin
            if (in_circle && in_frame) begin
                we_next   = 1'b1;
                addr_next = {pixel_index[ADDR_W-3:0], 2'b00};
            end
            last_next = 1'b0;
            if (row_inc >= span) begin
                scan_row_next = '0;
                if (col_inc >= span) begin
                    scan_col_next = '0;
                    active_next   = 1'b0;
                    last_next     = 1'b1;
                end else begin
                    scan_col_next = col_inc[HALF_W-1:0];
                end
            end else begin
                scan_row_next = row_inc[HALF_W-1:0];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= DIM_W'(640);
            frame_height_reg <= DIM_W'(480);
        end else if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // Scan state, updated per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg  <= '0;
            scan_row_reg  <= '0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            half_size_reg <= '0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            alpha_reg     <= '0;
            active_reg    <= 1'b0;
        end else if (accept) begin
            scan_col_reg  <= scan_col_next;
            scan_row_reg  <= scan_row_next;
            center_x_reg  <= center_x_next;
            center_y_reg  <= center_y_next;
            half_size_reg <= half_size_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            alpha_reg     <= alpha_next;
            active_reg    <= active_next;
        end
    end

    // Output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            we_reg   <= we_next;
            addr_reg <= addr_next;
            last_reg <= last_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_write_enable  = we_reg;
    assign m_byte_address  = addr_reg;
    // colour registers hold the value seen by the word now in the output stage
    assign m_out_red       = red_reg;
    assign m_out_green     = green_reg;
    assign m_out_blue      = blue_reg;
    assign m_out_alpha     = alpha_reg;
    assign m_last_position = last_reg;

endmodule

### sim/fcr_checker.sv
// Checker for the filled circle rasterizer: predicts each result word and compares it.
module fcr_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_write,
    input  logic                        cfg_index,
    input  logic [fcr_pkg::DIM_W-1:0]   cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic                        s_action,
    input  logic [fcr_pkg::COORD_W-1:0] s_center_x,
    input  logic [fcr_pkg::COORD_W-1:0] s_center_y,
    input  logic [fcr_pkg::DIAM_W-1:0]  s_diameter,
    input  logic [fcr_pkg::CHAN_W-1:0]  s_red,
    input  logic [fcr_pkg::CHAN_W-1:0]  s_green,
    input  logic [fcr_pkg::CHAN_W-1:0]  s_blue,
    input  logic [fcr_pkg::CHAN_W-1:0]  s_alpha,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic                        m_write_enable,
    input  logic [fcr_pkg::ADDR_W-1:0]  m_byte_address,
    input  logic [fcr_pkg::CHAN_W-1:0]  m_out_red,
    input  logic [fcr_pkg::CHAN_W-1:0]  m_out_green,
    input  logic [fcr_pkg::CHAN_W-1:0]  m_out_blue,
    input  logic [fcr_pkg::CHAN_W-1:0]  m_out_alpha,
    input  logic                        m_last_position,
    output int                          mismatches,
    output int                          words_owed
);
    import fcr_pkg::*;

    typedef struct {
        logic              write_enable;
        logic [ADDR_W-1:0] byte_address;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
        logic              last_position;
    } pixel_word_t;

    pixel_word_t pixels_due[$];
    int fault_count = 0;
    int owed_count  = 0;

    // predicted block state and configuration
    logic [DIM_W-1:0]    frame_w;
    logic [DIM_W-1:0]    frame_h;
    int                  scan_col;
    int                  scan_row;
    int                  centre_x;
    int                  centre_y;
    int                  half_size;
    logic [4*CHAN_W-1:0] held_rgba;
    logic                scan_active;

    assign mismatches = fault_count;
    assign words_owed = owed_count;

    // Next pixel word for one accepted input word; advances the scan
    task automatic rasterize_word(input logic act, input logic [COORD_W-1:0] cx,
                                  input logic [COORD_W-1:0] cy,
                                  input logic [DIAM_W-1:0] diam,
                                  input logic [4*CHAN_W-1:0] rgba);
        pixel_word_t res;
        longint h, dx, dy, px, py, fw, fh;
        int d, span;
        res.write_enable  = 1'b0;
        res.byte_address  = '0;
        res.last_position = 1'b1;
        if (act == ACT_START) begin
            d = (diam > MAX_DIAMETER) ? MAX_DIAMETER : int'(diam);
            centre_x    = $signed(cx);
            centre_y    = $signed(cy);
            half_size   = d / 2;
            held_rgba   = rgba;
            scan_col    = 0;
            scan_row    = 0;
            scan_active = (half_size != 0);
            res.last_position = !scan_active;
        end else if (scan_active) begin
            h  = half_size;
            dx = scan_col - h;
            dy = scan_row - h;
            px = centre_x + dx;
            py = centre_y + dy;
            fw = (frame_w > MAX_FRAME_DIM) ? MAX_FRAME_DIM : frame_w;
            fh = (frame_h > MAX_FRAME_DIM) ? MAX_FRAME_DIM : frame_h;
            if (dx * dx + dy * dy < h * h && px >= 0 && px < fw && py >= 0 && py < fh) begin
                res.write_enable = 1'b1;
                res.byte_address = ADDR_W'(4 * (fw * py + px));
            end
            // rows inner, columns outer
            res.last_position = 1'b0;
            span = 2 * half_size;
            scan_row++;
            if (scan_row >= span) begin
                scan_row = 0;
                scan_col++;
                if (scan_col >= span) begin
                    scan_col    = 0;
                    scan_active = 1'b0;
                    res.last_position = 1'b1;
                end
            end
        end
        res.red   = held_rgba[CHAN_W-1:0];
        res.green = held_rgba[2*CHAN_W-1:CHAN_W];
        res.blue  = held_rgba[3*CHAN_W-1:2*CHAN_W];
        res.alpha = held_rgba[4*CHAN_W-1:3*CHAN_W];
        pixels_due.push_back(res);
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            fault_count++;
            $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        pixel_word_t oldest;
        if (!aresetn) begin
            frame_w     = DIM_W'(640);
            frame_h     = DIM_W'(480);
            scan_col    = 0;
            scan_row    = 0;
            centre_x    = 0;
            centre_y    = 0;
            half_size   = 0;
            held_rgba   = '0;
            scan_active = 1'b0;
            pixels_due.delete();
        end else begin
            // result side first: a word never leaves in the cycle it enters
            if (m_valid && m_ready) begin
                if (pixels_due.size() == 0) begin
                    fault_count++;
                    $display("%0t: unexpected word: we %0b addr %0h last %0b", $time,
                             m_write_enable, m_byte_address, m_last_position);
                end else begin
                    oldest = pixels_due.pop_front();
                    check_field("write_enable", oldest.write_enable, m_write_enable);
                    check_field("byte_address", oldest.byte_address, m_byte_address);
                    check_field("out_red", oldest.red, m_out_red);
                    check_field("out_green", oldest.green, m_out_green);
                    check_field("out_blue", oldest.blue, m_out_blue);
                    check_field("out_alpha", oldest.alpha, m_out_alpha);
                    check_field("last_position", oldest.last_position, m_last_position);
                end
            end
            if (cfg_write) begin
                if (cfg_index == CFG_FRAME_WIDTH)
                    frame_w = cfg_data;
                else
                    frame_h = cfg_data;
            end
            if (s_valid && s_ready)
                rasterize_word(s_action, s_center_x, s_center_y, s_diameter,
                               {s_alpha, s_blue, s_green, s_red});
        end
        owed_count = pixels_due.size();
    end

endmodule

### sim/tb_filled_circle_rasterizer.sv
// Testbench top for the filled circle rasterizer: stimulus, flow control and verdict.
module tb_filled_circle_rasterizer;
    import fcr_pkg::*;

    localparam int QUIET_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_WORDS     = 160;
    localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;

    logic               aclk;
    logic               aresetn;
    logic               cfg_write;
    logic               cfg_index;
    logic [DIM_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [COORD_W-1:0] s_center_x;
    logic [COORD_W-1:0] s_center_y;
    logic [DIAM_W-1:0]  s_diameter;
    logic [CHAN_W-1:0]  s_red;
    logic [CHAN_W-1:0]  s_green;
    logic [CHAN_W-1:0]  s_blue;
    logic [CHAN_W-1:0]  s_alpha;
    logic               m_valid;
    logic               m_ready;
    logic               m_write_enable;
    logic [ADDR_W-1:0]  m_byte_address;
    logic [CHAN_W-1:0]  m_out_red;
    logic [CHAN_W-1:0]  m_out_green;
    logic [CHAN_W-1:0]  m_out_blue;
    logic [CHAN_W-1:0]  m_out_alpha;
    logic               m_last_position;

    int   mismatches;
    int   words_owed;
    int   words_sent   = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_off_req;

    filled_circle_rasterizer uut (.*);
    fcr_checker              scoreboard (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_ready   <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one word and hold it until accepted; called and returns at a falling edge
    task automatic send_word(input action_t act, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [DIAM_W-1:0] diam,
                             input logic [4*CHAN_W-1:0] rgba);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_center_x <= cx;
        s_center_y <= cy;
        s_diameter <= diam;
        {s_alpha, s_blue, s_green, s_red} <= rgba;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // Step words carry random payload, which the block ignores
    task automatic step_scan(input int count);
        repeat (count)
            send_word(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom),
                      DIAM_W'($urandom), $urandom);
    endtask

    // Centre coordinate around the frame so that clipping on both sides is hit
    function automatic logic [COORD_W-1:0] near_edge(input int dim, input int half);
        int lo, hi, v;
        if ($urandom_range(7) == 0)
            return COORD_W'($urandom);
        lo = -half - 3;
        hi = dim + half + 2;
        v  = lo + int'($urandom_range(hi - lo));
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < -COORD_MAX - 1)
            v = -COORD_MAX - 1;
        return COORD_W'(v);
    endfunction

    // Drain, set the frame, then mostly whole circles with random content
    task automatic run_phase(input int fw, input int fh, input bit squeeze);
        int goal, pick, half, steps, eff_w, eff_h;
        logic [DIAM_W-1:0] diam;
        goal = words_sent + PHASE_WORDS;
        s_valid <= 1'b0;
        while (words_owed != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= DIM_W'(fw);
        @(negedge aclk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= DIM_W'(fh);
        @(negedge aclk);
        cfg_write <= 1'b0;
        if (squeeze)
            hold_off_req <= 1'b1;
        eff_w = (fw > MAX_FRAME_DIM) ? MAX_FRAME_DIM : fw;
        eff_h = (fh > MAX_FRAME_DIM) ? MAX_FRAME_DIM : fh;
        while (words_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                if ($urandom_range(19) == 0)
                    diam = DIAM_W'($urandom);
                else
                    diam = DIAM_W'($urandom_range(12));
                half  = ((diam > MAX_DIAMETER) ? MAX_DIAMETER : int'(diam)) / 2;
                steps = 4 * half * half;
                // big boxes and broken sequences are cut short by the next start
                if (steps > 150)
                    steps = $urandom_range(150);
                else if (pick >= 75)
                    steps = $urandom_range(steps);
                else
                    steps += $urandom_range(2);
                send_word(ACT_START, near_edge(eff_w, half), near_edge(eff_h, half),
                          diam, $urandom);
                step_scan(steps);
            end else if (pick < 95) begin
                step_scan(1);
            end else begin
                send_word(ACT_START, COORD_W'($urandom), COORD_W'($urandom),
                          DIAM_W'($urandom), $urandom);
            end
        end
        // empty box leaves the block idle
        send_word(ACT_START, '0, '0, DIAM_W'(1), $urandom);
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_FRAME_WIDTH;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_action      = ACT_START;
        s_center_x    = '0;
        s_center_y    = '0;
        s_diameter    = '0;
        s_red         = '0;
        s_green       = '0;
        s_blue        = '0;
        s_alpha       = '0;
        hold_off_req  = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 83;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words on the reset frame of 640x480
        step_scan(1);                                            // step with nothing loaded
        send_word(ACT_START, '0, '0, '0, 32'h0000_0000);        // zero diameter
        send_word(ACT_START, COORD_W'(COORD_MAX), COORD_W'(-COORD_MAX - 1),
                  DIAM_W'(1), 32'hFFFF_FFFF);                    // odd diameter rounds to empty
        step_scan(1);                                            // idle step keeps the colour
        send_word(ACT_START, '0, '0, DIAM_W'(2), 32'h8040_2010);
        step_scan(5);                                            // full box plus one idle step
        send_word(ACT_START, COORD_W'(639), COORD_W'(479), DIAM_W'(2), 32'h0102_0304);
        step_scan(4);                                            // far corner of the frame
        send_word(ACT_START, COORD_W'(-1), COORD_W'(-1), '1, 32'h55AA_33CC);
        step_scan(3);                                            // saturated diameter, cut short
        send_word(ACT_START, COORD_W'(640), COORD_W'(480), DIAM_W'(6), 32'hDEAD_BEEF);
        step_scan(5);                                            // centre past the far corner, cut short
        send_word(ACT_START, '0, '0, DIAM_W'(1), 32'h1234_5678);

        // sender idles lightly, receiver heavily
        run_phase(16, 16, 1'b0);
        run_phase(4096, 4096, 1'b0);
        // and the other way round, with out-of-range frame values
        send_idle_pct = 83;
        recv_idle_pct = 23;
        run_phase(0, 8191, 1'b0);
        run_phase(8191, 1, 1'b0);
        // full rate, with one long hold-off on the result side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(1, 4096, 1'b1);
        run_phase(300, 200, 1'b0);

        s_valid <= 1'b0;
        while (words_owed != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
src/fcr_pkg.sv
src/filled_circle_rasterizer.sv
sim/fcr_checker.sv
sim/tb_filled_circle_rasterizer.sv
